// ----- rtl/slt_pkg.sv -----
// package: shared constants, codes and types for the stereo lesion triangulation block
`timescale 1ns / 1ps

package slt_pkg;

    localparam int DEF_COORD_BITS = 12;
    localparam int DEF_FRAC_BITS  = 16;

    // gains are unsigned q3.13
    localparam int GAIN_FRAC = 13;

    // focus-to-rotation geometry, L = 6127.5*sin(15), H = 6127.5*cos(15), scaled by 1e9
    localparam longint unsigned L_NUM     = 64'd1585913667600;
    localparam longint unsigned H_NUM     = 64'd5918710523325;
    localparam longint unsigned CONST_DEN = 64'd1000000000;

    localparam int REF_Y_BIAS = 470;
    localparam int TURRET_X0  = 260;
    localparam int TURRET_Y0  = 470;
    localparam int TURRET_Z0  = 1730;
    localparam int MIN_FIBRE  = 40;

    localparam logic [15:0] RST_GAIN_X = 16'd15425;
    localparam logic [15:0] RST_GAIN_Y = 16'd7971;
    localparam logic [7:0]  RST_FIBRE  = 8'd170;

    typedef enum logic [2:0] {
        REG_GAIN_X,
        REG_GAIN_Y,
        REG_OFFSET_X,
        REG_OFFSET_Y,
        REG_OFFSET_Z,
        REG_FIBRE
    } reg_idx_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_BAD_REF,
        ERR_TOO_LOW,
        ERR_TOO_HIGH
    } err_code_t;

    // per-item flags that ride along the pipeline
    typedef struct packed {
        logic       bad;
        logic       tneg;
        logic [7:0] thick;
    } side_t;

endpackage

// ----- rtl/slt_div.sv -----
// module: pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module slt_div #(
    parameter int NW  = 68,
    parameter int DPW = 50,
    parameter int QB  = 18
) (
    input  logic           clk,
    input  logic [QB-1:0]  en,
    input  logic [NW-1:0]  num,
    input  logic [DPW-1:0] dp,
    output logic [QB-1:0]  q
);

    logic [NW-1:0]  rem_reg [QB-1];
    logic [DPW-1:0] dp_reg  [QB-1];
    logic [QB-1:0]  q_reg   [QB];

    for (genvar j = 0; j < QB; j++)
    begin : g_st
        localparam int K = QB - 1 - j;
        logic [NW-1:0]  rin;
        logic [NW-1:0]  dsh;
        logic [DPW-1:0] din;
        logic [QB-1:0]  qin;
        logic [QB-1:0]  qn;
        logic           ge;

        if (j == 0)
        begin : g_first
            assign rin = num;
            assign din = dp;
            assign qin = '0;
        end
        else
        begin : g_rest
            assign rin = rem_reg[j-1];
            assign din = dp_reg[j-1];
            assign qin = q_reg[j-1];
        end

        // divisor aligned to this quotient bit
        assign dsh = NW'(din) << K;
        assign ge  = (rin >= dsh);

        always_comb
        begin
            qn    = qin;
            qn[K] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                q_reg[j] <= qn;
            end
        end

        if (j < QB - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en[j])
                begin
                    rem_reg[j] <= ge ? (rin - dsh) : rin;
                    dp_reg[j]  <= din;
                end
            end
        end
    end

    assign q = q_reg[QB-1];

endmodule

// ----- rtl/stereo_lesion_triangulation.sv -----
// top level: stereo pair lesion triangulation pipeline with apb register bank
`timescale 1ns / 1ps

// channel   direction  handshake            transaction
// input     in         in_valid / in_stall  8 mark coordinates + thickness
// output    out        out_valid / out_stall lesion position, fibre distance, status
// config    apb        psel/penable/pwrite  one register write or read
//
// one transaction per cycle sustained while out_stall is low; QB is the quotient
// width of the three parallel restoring dividers (18 at default widths)
// the divider bit stages set the depth; each holds one wide compare and subtract
// reset clears valid bits and loads the default calibration, no clearing pass
// a stall freezes only stages that are full downstream, so bubbles keep filling

module stereo_lesion_triangulation #(
    parameter int COORD_BITS = slt_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = slt_pkg::DEF_FRAC_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input transaction
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_BITS-1:0] ref_plus_x,
    input  logic [COORD_BITS-1:0] ref_plus_y,
    input  logic [COORD_BITS-1:0] les_plus_x,
    input  logic [COORD_BITS-1:0] les_plus_y,
    input  logic [COORD_BITS-1:0] ref_minus_x,
    input  logic [COORD_BITS-1:0] ref_minus_y,
    input  logic [COORD_BITS-1:0] les_minus_x,
    input  logic [COORD_BITS-1:0] les_minus_y,
    input  logic [7:0]            thickness_mm,
    // output transaction
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [15:0]    lesion_x,
    output logic signed [15:0]    lesion_y,
    output logic signed [15:0]    lesion_z,
    output logic signed [15:0]    fibre_distance,
    output logic                  lesion_ok,
    output logic [1:0]            error_code,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    import slt_pkg::*;

    // widths
    localparam int RW   = COORD_BITS + 16;                       // raw * gain
    localparam int SHL  = (FRAC_BITS > GAIN_FRAC) ? FRAC_BITS - GAIN_FRAC : 0;
    localparam int SHR  = (FRAC_BITS < GAIN_FRAC) ? GAIN_FRAC - FRAC_BITS : 0;
    localparam int SW   = RW + SHL;                              // scaled coordinate
    localparam int EW   = ((SW > FRAC_BITS + 9) ? SW : FRAC_BITS + 9) + 2;
    localparam int LW   = FRAC_BITS + 11;
    localparam int CW   = FRAC_BITS + 13;                        // constant operand
    localparam int DW   = ((EW > LW + 1) ? EW : LW + 1) + 1;     // denominator
    localparam int DPW  = DW + FRAC_BITS;
    localparam int QB   = ((EW - FRAC_BITS > 13) ? EW - FRAC_BITS : 13) + 1;
    localparam int VW   = EW + 1;                                // multiplier variable
    localparam int LOWB = VW / 2;
    localparam int HIB  = VW - LOWB;
    localparam int PW   = VW + CW;
    localparam int NW   = (PW > DPW + QB) ? PW : DPW + QB;
    localparam int FW   = QB + 5;

    // geometry constants truncated to the fraction width
    localparam longint unsigned LQ = ((L_NUM / CONST_DEN) << FRAC_BITS)
                                   + (((L_NUM % CONST_DEN) << FRAC_BITS) / CONST_DEN);
    localparam longint unsigned HQ = ((H_NUM / CONST_DEN) << FRAC_BITS)
                                   + (((H_NUM % CONST_DEN) << FRAC_BITS) / CONST_DEN);
    localparam logic [CW-1:0] LQ_C  = CW'(LQ);
    localparam logic [CW-1:0] LQ2_C = CW'(LQ << 1);
    localparam logic [CW-1:0] HQ_C  = CW'(HQ);
    localparam logic [EW-1:0] YBIAS = EW'(REF_Y_BIAS) << FRAC_BITS;

    // stage numbering
    localparam int ST_DIFF = 1;
    localparam int ST_ABS  = 2;
    localparam int ST_DEN  = 3;
    localparam int ST_PP   = 4;
    localparam int ST_SUM  = 5;
    localparam int ST_DIV0 = 6;
    localparam int ST_FIN  = ST_DIV0 + QB;
    localparam int ST_OUT  = ST_FIN + 1;
    localparam int NS      = ST_OUT + 1;

    // ------------------------------------------------------------------
    // register bank
    // ------------------------------------------------------------------
    logic [15:0]       gain_x_reg;
    logic [15:0]       gain_y_reg;
    logic signed [11:0] offset_x_reg;
    logic signed [11:0] offset_y_reg;
    logic signed [11:0] offset_z_reg;
    logic [7:0]        fibre_reg;
    reg_idx_t          reg_idx;
    logic              wr_en;

    assign reg_idx = reg_idx_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_x_reg   <= RST_GAIN_X;
            gain_y_reg   <= RST_GAIN_Y;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            offset_z_reg <= '0;
            fibre_reg    <= RST_FIBRE;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_GAIN_X:   gain_x_reg   <= pwdata[15:0];
                REG_GAIN_Y:   gain_y_reg   <= pwdata[15:0];
                REG_OFFSET_X: offset_x_reg <= pwdata[11:0];
                REG_OFFSET_Y: offset_y_reg <= pwdata[11:0];
                REG_OFFSET_Z: offset_z_reg <= pwdata[11:0];
                REG_FIBRE:    fibre_reg    <= pwdata[7:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_GAIN_X:   prdata = {16'd0, gain_x_reg};
            REG_GAIN_Y:   prdata = {16'd0, gain_y_reg};
            REG_OFFSET_X: prdata = {20'd0, offset_x_reg};
            REG_OFFSET_Y: prdata = {20'd0, offset_y_reg};
            REG_OFFSET_Z: prdata = {20'd0, offset_z_reg};
            REG_FIBRE:    prdata = {24'd0, fibre_reg};
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline flow: a stage loads when it is empty or its successor moves
    // ------------------------------------------------------------------
    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    assign en[NS-1] = !v_reg[NS-1] || !out_stall;
    for (genvar i = 0; i < NS - 1; i++)
    begin : g_en
        assign en[i] = !v_reg[i] || en[i+1];
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // side flags travel with each transaction up to the final stage
    side_t sb_reg [ST_OUT];
    logic  tneg_d;

    for (genvar i = 1; i < ST_OUT; i++)
    begin : g_sb
        side_t sb_next;
        always_comb
        begin
            sb_next = sb_reg[i-1];
            if (i == ST_DEN)
            begin
                sb_next.tneg = tneg_d;
            end
        end
        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                sb_reg[i] <= sb_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 0: scale the eight coordinates by the axis gains
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0] raw [8];
    logic [SW-1:0]         s_next [8];
    logic [SW-1:0]         s_reg  [8];
    logic                  bad_d;

    assign raw[0] = ref_plus_x;
    assign raw[1] = ref_plus_y;
    assign raw[2] = les_plus_x;
    assign raw[3] = les_plus_y;
    assign raw[4] = ref_minus_x;
    assign raw[5] = ref_minus_y;
    assign raw[6] = les_minus_x;
    assign raw[7] = les_minus_y;

    always_comb
    begin
        logic [RW-1:0] pr;
        bad_d = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            pr = RW'(raw[i]) * RW'(i[0] ? gain_y_reg : gain_x_reg);
            if (FRAC_BITS >= GAIN_FRAC)
            begin
                s_next[i] = SW'(pr) << SHL;
            end
            else
            begin
                s_next[i] = SW'(pr >> SHR);
            end
            // a zero coordinate marks an unusable reference
            if (s_next[i] == '0)
            begin
                bad_d = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s_reg        <= s_next;
            sb_reg[0]    <= '{bad: bad_d, tneg: 1'b0, thick: thickness_mm};
        end
    end

    // ------------------------------------------------------------------
    // stage 1: image-space differences
    // ------------------------------------------------------------------
    logic signed [EW-1:0] xp_reg, yp_reg, xm_reg, ym_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_DIFF])
        begin
            xp_reg <= EW'(s_reg[0]) - EW'(s_reg[2]);
            yp_reg <= YBIAS + EW'(s_reg[1]) - EW'(s_reg[3]);
            xm_reg <= EW'(s_reg[4]) - EW'(s_reg[6]);
            ym_reg <= YBIAS + EW'(s_reg[5]) - EW'(s_reg[7]);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: stereo shift magnitudes
    // ------------------------------------------------------------------
    logic signed [EW-1:0] dx_d;
    logic signed [EW:0]   sy_d;
    logic [EW:0]          sy_mag;
    logic [EW-1:0]        xmp2_reg, ymp2_reg;
    logic signed [EW-1:0] xp2_reg;

    assign dx_d   = xm_reg - xp_reg;
    assign sy_d   = {ym_reg[EW-1], ym_reg} + {yp_reg[EW-1], yp_reg};
    assign sy_mag = sy_d[EW] ? (EW+1)'(-sy_d) : (EW+1)'(sy_d);

    always_ff @(posedge clk)
    begin
        if (en[ST_ABS])
        begin
            xmp2_reg <= dx_d[EW-1] ? EW'(-dx_d) : EW'(dx_d);
            ymp2_reg <= sy_mag[EW:1];
            xp2_reg  <= xp_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: denominator and x numerator term
    // ------------------------------------------------------------------
    logic signed [EW+1:0] t_d;
    logic [DW-1:0]        den3_reg;
    logic [VW-1:0]        at3_reg;
    logic [EW-1:0]        xmp3_reg, ymp3_reg;

    assign t_d    = ({{2{xp2_reg[EW-1]}}, xp2_reg} <<< 1) + (EW+2)'(xmp2_reg);
    assign tneg_d = t_d[EW+1];

    always_ff @(posedge clk)
    begin
        if (en[ST_DEN])
        begin
            den3_reg <= DW'(xmp2_reg) + DW'(LQ2_C);
            at3_reg  <= tneg_d ? VW'(-t_d) : VW'(t_d);
            xmp3_reg <= xmp2_reg;
            ymp3_reg <= ymp2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: partial products, split variable operand
    // ------------------------------------------------------------------
    logic [VW-1:0]       var_d [3];
    logic [CW-1:0]       cst   [3];
    logic [LOWB+CW-1:0]  pl_reg [3];
    logic [HIB+CW-1:0]   ph_reg [3];
    logic [DPW-1:0]      dp4_reg;

    // lane 0: z, lane 1: x, lane 2: y
    assign var_d[0] = VW'(xmp3_reg);
    assign var_d[1] = at3_reg;
    assign var_d[2] = VW'(ymp3_reg);
    assign cst[0]   = HQ_C;
    assign cst[1]   = LQ_C;
    assign cst[2]   = LQ2_C;

    always_ff @(posedge clk)
    begin
        if (en[ST_PP])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pl_reg[i] <= (LOWB+CW)'(var_d[i][LOWB-1:0]) * (LOWB+CW)'(cst[i]);
                ph_reg[i] <= (HIB+CW)'(var_d[i][VW-1:LOWB]) * (HIB+CW)'(cst[i]);
            end
            dp4_reg <= {den3_reg, {FRAC_BITS{1'b0}}};
        end
    end

    // ------------------------------------------------------------------
    // stage 5: full numerators
    // ------------------------------------------------------------------
    logic [NW-1:0]  num5_reg [3];
    logic [DPW-1:0] dp5_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            for (int i = 0; i < 3; i++)
            begin
                num5_reg[i] <= (NW'(ph_reg[i]) << LOWB) + NW'(pl_reg[i]);
            end
            dp5_reg <= dp4_reg;
        end
    end

    // ------------------------------------------------------------------
    // divider stages: integer quotients truncated toward zero
    // ------------------------------------------------------------------
    logic [QB-1:0] q [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        slt_div #(
            .NW  (NW),
            .DPW (DPW),
            .QB  (QB)
        ) u_div (
            .clk (clk),
            .en  (en[ST_DIV0 +: QB]),
            .num (num5_reg[i]),
            .dp  (dp5_reg),
            .q   (q[i])
        );
    end

    // ------------------------------------------------------------------
    // final stage: turret coordinates and fibre distance
    // ------------------------------------------------------------------
    logic signed [FW-1:0] zi_d, xi_d, yi_d, lz_d, fo10_d;
    logic signed [FW-1:0] lx_reg, ly_reg, lz_reg, zf_reg;

    assign zi_d   = FW'(q[0]);
    assign xi_d   = sb_reg[ST_FIN-1].tneg ? -FW'(q[1]) : FW'(q[1]);
    assign yi_d   = FW'(q[2]);
    assign lz_d   = FW'(TURRET_Z0) - zi_d + {{(FW-12){offset_z_reg[11]}}, offset_z_reg};
    assign fo10_d = (FW'(fibre_reg) << 3) + (FW'(fibre_reg) << 1);

    always_ff @(posedge clk)
    begin
        if (en[ST_FIN])
        begin
            lx_reg <= FW'(TURRET_X0) - xi_d + {{(FW-12){offset_x_reg[11]}}, offset_x_reg};
            ly_reg <= FW'(TURRET_Y0) - yi_d + {{(FW-12){offset_y_reg[11]}}, offset_y_reg};
            lz_reg <= lz_d;
            zf_reg <= fo10_d - lz_d;
        end
    end

    // ------------------------------------------------------------------
    // output stage: classification and saturation
    // ------------------------------------------------------------------
    function automatic logic signed [15:0] sat16(input logic signed [FW-1:0] v);
        logic signed [15:0] r;
        if (v > FW'(32767))
        begin
            r = 16'sd32767;
        end
        else if (v < -FW'(32768))
        begin
            r = -16'sd32768;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    side_t                sb_fin;
    logic signed [FW-1:0] th10_d;
    err_code_t            err_d;
    logic signed [15:0]   lx_out_reg, ly_out_reg, lz_out_reg, zf_out_reg;
    logic                 ok_out_reg;
    err_code_t            err_out_reg;

    assign sb_fin = sb_reg[ST_FIN];
    assign th10_d = (FW'(sb_fin.thick) << 3) + (FW'(sb_fin.thick) << 1);

    always_comb
    begin
        if (sb_fin.bad)
        begin
            err_d = ERR_BAD_REF;
        end
        else if (zf_reg <= FW'(MIN_FIBRE))
        begin
            err_d = ERR_TOO_LOW;
        end
        else if (zf_reg >= th10_d)
        begin
            err_d = ERR_TOO_HIGH;
        end
        else
        begin
            err_d = ERR_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            // unusable references force every position field to zero
            lx_out_reg  <= sb_fin.bad ? '0 : sat16(lx_reg);
            ly_out_reg  <= sb_fin.bad ? '0 : sat16(ly_reg);
            lz_out_reg  <= sb_fin.bad ? '0 : sat16(lz_reg);
            zf_out_reg  <= sb_fin.bad ? '0 : sat16(zf_reg);
            ok_out_reg  <= (err_d == ERR_NONE);
            err_out_reg <= err_d;
        end
    end

    assign lesion_x       = lx_out_reg;
    assign lesion_y       = ly_out_reg;
    assign lesion_z       = lz_out_reg;
    assign fibre_distance = zf_out_reg;
    assign lesion_ok      = ok_out_reg;
    assign error_code     = err_out_reg;

`ifndef SYNTHESIS
    // input backs up only when every stage is full and the output is held
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while pipeline has room");

    a_ok_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (lesion_ok == (error_code == ERR_NONE)))
        else $error("lesion_ok disagrees with error_code");

    a_bad_ref_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error_code == ERR_BAD_REF) |->
            (lesion_x == 16'sd0 && lesion_z == 16'sd0 && fibre_distance == 16'sd0))
        else $error("invalid reference result carries a position");
`endif

endmodule

// ----- tb/testbench.sv -----
// testbench for the stereo lesion triangulation block: random and directed stimulus, scoreboard
`timescale 1ns / 1ps

module testbench;
    import slt_pkg::*;

    localparam int CW        = DEF_COORD_BITS;
    localparam int WDOG_MAX  = 3000;   // idle cycles before giving up
    localparam int DRAIN_CYC = 40;     // idle margin once no result is outstanding
    localparam int HOLD_CYC  = 300;    // long receiver hold-off

    // one input transaction
    typedef struct {
        logic [CW-1:0] mark[8];  // rp_x rp_y lp_x lp_y rm_x rm_y lm_x lm_y
        logic [7:0]    thick;
    } marks_t;

    // one output transaction
    typedef struct {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] fibre;
        logic               ok;
        err_code_t          err;
    } lesion_t;

    // scoreboard: holds calibration and the queue of predicted lesion positions
    class lesion_scoreboard;
        longint unsigned gx, gy, fib;
        longint          ox, oy, oz;
        lesion_t         pending_q[$];
        int              n_err;

        function new();
            gx = RST_GAIN_X; gy = RST_GAIN_Y; fib = RST_FIBRE;
            ox = 0; oy = 0; oz = 0;
            n_err = 0;
        endfunction

        function void set_reg(reg_idx_t r, logic [31:0] v);
            case (r)
                REG_GAIN_X:   gx = v[15:0];
                REG_GAIN_Y:   gy = v[15:0];
                REG_OFFSET_X: ox = longint'($signed(v[11:0]));
                REG_OFFSET_Y: oy = longint'($signed(v[11:0]));
                REG_OFFSET_Z: oz = longint'($signed(v[11:0]));
                REG_FIBRE:    fib = v[7:0];
                default: ;
            endcase
        endfunction

        function logic signed [15:0] clip16(longint v);
            if (v > 32767) return 16'sh7fff;
            if (v < -32768) return 16'sh8000;
            return v[15:0];
        endfunction

        // floor(a*b/d) with the fraction dropped
        function longint unsigned scaled_quot(longint unsigned a, longint unsigned b,
                                              longint unsigned d);
            logic [127:0] w;
            w = {64'd0, a} * {64'd0, b};
            w = w / {64'd0, d};
            return w[79:16];
        endfunction

        // triangulate one stereo pair and queue the expected lesion transaction
        function void note_marks(marks_t m);
            longint unsigned s[8];
            longint unsigned lq, hq, xmp, ymp, den, mq;
            longint          xp, yp, xm, ym, t, xi, yi, zi, lx, ly, lz, zf;
            bit              bad;
            lesion_t         e;
            bad = 0;
            for (int i = 0; i < 8; i++) begin
                // gain is q3.13, values carry 16 fraction bits
                s[i] = (longint'(m.mark[i]) * ((i % 2) ? gy : gx)) << 3;
                if (s[i] == 0) bad = 1;
            end
            if (bad) begin
                e.pos_x = 0; e.pos_y = 0; e.pos_z = 0; e.fibre = 0;
                e.ok = 0; e.err = ERR_BAD_REF;
                pending_q.push_back(e);
                return;
            end
            lq = ((L_NUM / CONST_DEN) << 16) + (((L_NUM % CONST_DEN) << 16) / CONST_DEN);
            hq = ((H_NUM / CONST_DEN) << 16) + (((H_NUM % CONST_DEN) << 16) / CONST_DEN);
            xp = longint'(s[0]) - longint'(s[2]);
            yp = (longint'(REF_Y_BIAS) << 16) + longint'(s[1]) - longint'(s[3]);
            xm = longint'(s[4]) - longint'(s[6]);
            ym = (longint'(REF_Y_BIAS) << 16) + longint'(s[5]) - longint'(s[7]);
            t = xm - xp;
            xmp = (t < 0) ? -t : t;
            t = ym + yp;
            ymp = ((t < 0) ? -t : t) / 2;
            den = xmp + 2 * lq;
            zi = scaled_quot(xmp, hq, den);
            t = 2 * xp + longint'(xmp);
            mq = scaled_quot(lq, (t < 0) ? -t : t, den);
            xi = (t < 0) ? -longint'(mq) : longint'(mq);
            yi = scaled_quot(2 * lq, ymp, den);
            lx = TURRET_X0 - xi + ox;
            ly = TURRET_Y0 - yi + oy;
            lz = TURRET_Z0 - zi + oz;
            zf = longint'(fib) * 10 - lz;
            // classification uses the unclipped height
            if (zf <= MIN_FIBRE) begin
                e.ok = 0; e.err = ERR_TOO_LOW;
            end
            else if (zf >= longint'(m.thick) * 10) begin
                e.ok = 0; e.err = ERR_TOO_HIGH;
            end
            else begin
                e.ok = 1; e.err = ERR_NONE;
            end
            e.pos_x = clip16(lx); e.pos_y = clip16(ly);
            e.pos_z = clip16(lz); e.fibre = clip16(zf);
            pending_q.push_back(e);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            n_err++;
        endtask

        task check_lesion(lesion_t got);
            lesion_t e;
            if (pending_q.size() == 0) begin
                report("result with nothing expected");
                return;
            end
            e = pending_q.pop_front();
            if (got.pos_x !== e.pos_x)
                report($sformatf("lesion_x %0d want %0d", got.pos_x, e.pos_x));
            if (got.pos_y !== e.pos_y)
                report($sformatf("lesion_y %0d want %0d", got.pos_y, e.pos_y));
            if (got.pos_z !== e.pos_z)
                report($sformatf("lesion_z %0d want %0d", got.pos_z, e.pos_z));
            if (got.fibre !== e.fibre)
                report($sformatf("fibre_distance %0d want %0d", got.fibre, e.fibre));
            if (got.ok !== e.ok)
                report($sformatf("lesion_ok %0b want %0b", got.ok, e.ok));
            if (got.err !== e.err)
                report($sformatf("error_code %0d want %0d", got.err, e.err));
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic [CW-1:0] ref_plus_x = 0, ref_plus_y = 0, les_plus_x = 0, les_plus_y = 0;
    logic [CW-1:0] ref_minus_x = 0, ref_minus_y = 0, les_minus_x = 0, les_minus_y = 0;
    logic [7:0] thickness_mm = 0;
    logic out_valid;
    logic out_stall = 0;
    logic signed [15:0] lesion_x, lesion_y, lesion_z, fibre_distance;
    logic lesion_ok;
    logic [1:0] error_code;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [4:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic pready;

    lesion_scoreboard sb = new();

    bit tx_gaps = 1;     // sender idles between transactions
    bit rx_gaps = 1;     // receiver stalls between transactions
    bit hold_req = 0;    // ask the receiver for one long hold-off
    int wdog = 0;

    stereo_lesion_triangulation u_top (.*);

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    // monitor both channels, feed the scoreboard, and watch for a hang
    always @(posedge clk)
    begin
        marks_t  m;
        lesion_t r;
        if (in_valid && !in_stall) begin
            m.mark[0] = ref_plus_x;  m.mark[1] = ref_plus_y;
            m.mark[2] = les_plus_x;  m.mark[3] = les_plus_y;
            m.mark[4] = ref_minus_x; m.mark[5] = ref_minus_y;
            m.mark[6] = les_minus_x; m.mark[7] = les_minus_y;
            m.thick = thickness_mm;
            sb.note_marks(m);
        end
        if (out_valid && !out_stall) begin
            r.pos_x = lesion_x; r.pos_y = lesion_y; r.pos_z = lesion_z;
            r.fibre = fibre_distance; r.ok = lesion_ok;
            r.err = err_code_t'(error_code);
            sb.check_lesion(r);
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stall per transaction, plus one long hold-off on request
    initial
    begin : rx_side
        int n;
        @(posedge rst_n);
        forever
        begin
            if (hold_req) begin
                out_stall <= 1;
                repeat (HOLD_CYC) @(posedge clk);
                hold_req = 0;
            end
            n = rx_gaps ? $urandom_range(0, 16) : 0;
            if (n > 0) begin
                out_stall <= 1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    task write_reg(reg_idx_t r, logic [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= 5'(r) << 2; pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.set_reg(r, v);
        @(posedge clk);
    endtask

    task write_cal(int gx, int gy, int ox, int oy, int oz, int fb);
        write_reg(REG_GAIN_X, gx);
        write_reg(REG_GAIN_Y, gy);
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_OFFSET_Z, oz);
        write_reg(REG_FIBRE, fb);
    endtask

    // offer one transaction, waiting out stalls; valid stays up on a zero gap
    task send_marks(marks_t m);
        int n;
        n = tx_gaps ? $urandom_range(0, 16) : 0;
        if (n > 0) begin
            in_valid <= 0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1;
        ref_plus_x <= m.mark[0];  ref_plus_y <= m.mark[1];
        les_plus_x <= m.mark[2];  les_plus_y <= m.mark[3];
        ref_minus_x <= m.mark[4]; ref_minus_y <= m.mark[5];
        les_minus_x <= m.mark[6]; les_minus_y <= m.mark[7];
        thickness_mm <= m.thick;
        do @(posedge clk); while (in_stall);
    endtask

    task drain();
        in_valid <= 0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    function marks_t same_marks(int v, int th);
        marks_t m;
        for (int i = 0; i < 8; i++) m.mark[i] = CW'(v);
        m.thick = 8'(th);
        return m;
    endfunction

    // mostly plausible pairs: lesion near its reference, minus near plus
    function marks_t random_marks();
        marks_t m;
        int kind, bx, by, d;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            // raw noise over the full field range
            for (int i = 0; i < 8; i++) m.mark[i] = CW'($urandom_range(0, (1 << CW) - 1));
        end
        else begin
            bx = $urandom_range(300, 3700);
            by = $urandom_range(300, 3700);
            d = (kind < 5) ? 30 : 250;
            m.mark[0] = CW'(bx);
            m.mark[1] = CW'(by);
            m.mark[2] = CW'(bx + $urandom_range(0, 2 * d) - d);
            m.mark[3] = CW'(by + $urandom_range(0, 2 * d) - d);
            m.mark[4] = CW'(bx + $urandom_range(0, 2 * d) - d);
            m.mark[5] = CW'(by + $urandom_range(0, 2 * d) - d);
            m.mark[6] = CW'(m.mark[4] + $urandom_range(0, 2 * d) - d);
            m.mark[7] = CW'(m.mark[5] + $urandom_range(0, 2 * d) - d);
        end
        // occasionally a missing mark, which flags invalid references
        if ($urandom_range(0, 24) == 0) m.mark[$urandom_range(0, 7)] = '0;
        m.thick = 8'($urandom_range(0, 255));
        return m;
    endfunction

    task random_phase(int count, bit with_hold, bit with_pause);
        for (int k = 0; k < count; k++) begin
            if (with_hold && k == 20) hold_req = 1;
            // sender waits for every outstanding result to come back
            if (with_pause && k == count / 2) begin
                in_valid <= 0;
                @(posedge clk);
                while (sb.pending_q.size() != 0) @(posedge clk);
            end
            // stretches with no idling on either side
            tx_gaps = !(k % 100 >= 70);
            rx_gaps = !(k % 100 >= 60 && k % 100 < 90);
            send_marks(random_marks());
        end
        tx_gaps = 1;
        rx_gaps = 1;
        drain();
    endtask

    initial
    begin : main
        marks_t m;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed transactions at reset calibration
        send_marks(same_marks((1 << CW) - 1, 255));   // all max
        send_marks(same_marks(0, 0));                 // all zero, invalid references
        send_marks(same_marks(1, 255));               // smallest nonzero
        send_marks(same_marks(2048, 0));              // too low: fibre distance below the minimum
        m = same_marks(2048, 200);
        m.mark[2] = 2000; m.mark[6] = 2100;           // off-center lesion
        send_marks(m);
        m.mark[3] = 0;                                // one missing mark
        send_marks(m);
        m = same_marks(1000, 120);
        m.mark[6] = 1400;                             // deep lesion
        send_marks(m);
        m.mark[6] = 600;                              // opposite parallax
        send_marks(m);
        m = same_marks(0, 255);
        m.mark[0] = CW'((1 << CW) - 1); m.mark[4] = CW'((1 << CW) - 1);
        m.mark[2] = 1; m.mark[6] = 1; m.mark[1] = 1; m.mark[3] = 4095;
        m.mark[5] = 1; m.mark[7] = 4095;              // extreme spread
        send_marks(m);
        m = same_marks(2730, 170);
        m.mark[2] = 2600; m.mark[6] = 2800;
        send_marks(m);
        drain();

        // gains of one: raw coordinates scale almost to nothing
        write_cal(1, 1, 0, 0, 0, 170);
        send_marks(same_marks(1, 255));
        send_marks(same_marks((1 << CW) - 1, 255));
        drain();

        random_phase(300, 0, 0);                      // gains of one

        write_cal($urandom_range(1, 65535), $urandom_range(1, 65535),
                  $urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(0, 4095), $urandom_range(0, 255));
        random_phase(250, 1, 0);                      // with a long receiver hold-off

        write_cal(65535, 65535, 2047, 2047, 2047, 255);
        random_phase(250, 0, 1);                      // with a sender pause

        write_cal(1, 1, -2048, -2048, -2048, 0);
        random_phase(200, 0, 0);

        write_cal(0, $urandom_range(1, 65535), 0, 0, 0, 170);   // zero gain, all invalid
        random_phase(60, 0, 0);

        write_cal(15425, 7971, $urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(0, 4095), $urandom_range(100, 255));
        random_phase(500, 0, 0);

        write_cal($urandom_range(1, 65535), $urandom_range(1, 65535),
                  $urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(0, 4095), $urandom_range(0, 255));
        random_phase(450, 0, 0);

        if (sb.n_err == 0 && sb.pending_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/slt_pkg.sv
rtl/slt_div.sv
rtl/stereo_lesion_triangulation.sv
tb/testbench.sv
